### hw/rtl/atmf_pkg.sv
package atmf_pkg;

    // field widths
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = 16;
    localparam int TUSER_W  = 8;

    // averaging structure
    localparam int READS_PER_ROUND = 5;
    localparam int ROUNDS          = 5;
    localparam int CNT_W           = 3;
    localparam int SUM_W           = 15;   // 5 * 4095 = 20475
    localparam int STORED_ROUNDS   = ROUNDS - 1;   // last round value is bypassed
    localparam int SLOT_W          = 2;

    // middle-three sum and final quotient
    localparam int TOTAL_W = 15;           // 5 * 4095
    localparam int MID_W   = 14;           // 3 * 4095 = 12285
    localparam int QUO_W   = 9;            // 12285 / 30 = 409

    // x / 5 for x < 2^15: (x * 26215) >> 17
    localparam int DIV5_MUL_W = 15;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 15'd26215;
    localparam int DIV5_SHIFT = 17;
    localparam int DIV5_PROD_W = SUM_W + DIV5_MUL_W;

    // x / 30 for x < 12288: (x * 17477) >> 19 ; /3 then /10 folds into /30
    localparam int DIV30_MUL_W = 15;
    localparam logic [DIV30_MUL_W-1:0] DIV30_MUL = 15'd17477;
    localparam int DIV30_SHIFT = 19;
    localparam int DIV30_PROD_W = MID_W + DIV30_MUL_W;

    typedef logic [SAMPLE_W-1:0] value_t;

endpackage

### hw/rtl/adc_trimmed_mean_filter.sv
// Trimmed-mean filter for tagged 12-bit converter samples. Each word on the
// slave side carries one sample (tdata) and its channel (tuser); tags of
// CHANNELS and above are dropped without effect. Per channel, every five
// samples form a round whose truncated mean is kept; after five rounds the
// lowest and highest round values are discarded, the middle three are
// averaged (truncated) and rounded down to a multiple of 10, and one word
// with the channel and that value leaves on the master side; the channel
// then starts over. Channels run independently. The block takes one word
// per clock while s_tready is high: the running sums and counts update at
// the accepting edge, and the round mean (one multiply), the min/max/sum of
// the five round values and the final divide by 30 (one multiply) plus the
// scale by 10 each sit in their own register stage, the last being the
// output register. Stages advance independently and collapse bubbles, so
// a result waiting on m_tready does not hold the input until four more
// results are queued behind it. The round-value store has no reset; only
// entries written in the current set of rounds are ever read.
module adc_trimmed_mean_filter #(
    parameter int CHANNELS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  logic [7:0]  s_tuser,   // [2:0] channel, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] filtered_value, [15:12] zero
    output logic [7:0]  m_tuser    // [2:0] out_channel, [7:3] zero
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------- per-channel accumulation state ----------------
    logic [atmf_pkg::CNT_W-1:0] read_count_reg  [CHANNELS];
    logic [atmf_pkg::SUM_W-1:0] read_sum_reg    [CHANNELS];
    logic [atmf_pkg::CNT_W-1:0] round_count_reg [CHANNELS];

    // round values, one row per channel; no reset
    atmf_pkg::value_t avg_mem [CHANNELS][atmf_pkg::STORED_ROUNDS];

    // ---------------- stage registers ----------------
    // round stage: a completed round sum waiting for its divide by 5
    logic                                rnd_valid_reg;
    logic                                rnd_final_reg;
    logic [CH_IDX_W-1:0]                 rnd_ch_reg;
    logic [atmf_pkg::SLOT_W-1:0]         rnd_slot_reg;
    logic [atmf_pkg::SUM_W-1:0]          rnd_sum_reg;

    // sort stage: the five round values of a finished channel
    logic                                srt_valid_reg;
    logic [CH_IDX_W-1:0]                 srt_ch_reg;
    atmf_pkg::value_t                    srt_vals_reg [atmf_pkg::ROUNDS];

    // middle-three sum
    logic                                mid_valid_reg;
    logic [CH_IDX_W-1:0]                 mid_ch_reg;
    logic [atmf_pkg::MID_W-1:0]          mid_sum_reg;

    // quotient by 30
    logic                                quo_valid_reg;
    logic [CH_IDX_W-1:0]                 quo_ch_reg;
    logic [atmf_pkg::QUO_W-1:0]          quo_reg;

    // output word
    logic                                out_valid_reg;
    logic [CH_IDX_W-1:0]                 out_ch_reg;
    atmf_pkg::value_t                    out_value_reg;

    // ---------------- stage enables ----------------
    logic en_out, en_quo, en_mid, en_srt, en_rnd;

    assign en_out = !out_valid_reg || m_tready;
    assign en_quo = !quo_valid_reg || en_out;
    assign en_mid = !mid_valid_reg || en_quo;
    assign en_srt = !srt_valid_reg || en_mid;
    // a non-final round only writes the store, so it never waits on the sorter
    assign en_rnd = !rnd_valid_reg || !rnd_final_reg || en_srt;

    assign s_tready = en_rnd;

    // ---------------- input decode ----------------
    logic [atmf_pkg::CH_W-1:0]     in_ch;
    logic [CH_IDX_W-1:0]           in_idx;
    logic                          in_ok;
    logic                          in_take;
    logic                          round_done;
    logic [atmf_pkg::SUM_W-1:0]    sum_next;

    assign in_ch      = s_tuser[atmf_pkg::CH_W-1:0];
    assign in_idx     = in_ch[CH_IDX_W-1:0];
    assign in_ok      = ({1'b0, in_ch} < 4'(CHANNELS));
    assign in_take    = s_tvalid && s_tready && in_ok;
    assign round_done = (read_count_reg[in_idx] ==
                         atmf_pkg::CNT_W'(atmf_pkg::READS_PER_ROUND - 1));
    assign sum_next   = read_sum_reg[in_idx]
                      + atmf_pkg::SUM_W'(s_tdata[atmf_pkg::SAMPLE_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                read_count_reg[i]  <= '0;
                read_sum_reg[i]    <= '0;
                round_count_reg[i] <= '0;
            end
        end
        else if (in_take)
        begin
            if (round_done)
            begin
                read_count_reg[in_idx] <= '0;
                read_sum_reg[in_idx]   <= '0;
                if (round_count_reg[in_idx] == atmf_pkg::CNT_W'(atmf_pkg::ROUNDS - 1))
                    round_count_reg[in_idx] <= '0;
                else
                    round_count_reg[in_idx] <= round_count_reg[in_idx] + 1'b1;
            end
            else
            begin
                read_count_reg[in_idx] <= read_count_reg[in_idx] + 1'b1;
                read_sum_reg[in_idx]   <= sum_next;
            end
        end
    end

    // ---------------- round stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_valid_reg <= 1'b0;
        else if (en_rnd)
            rnd_valid_reg <= in_take && round_done;
    end

    always_ff @(posedge clk)
    begin
        if (en_rnd)
        begin
            rnd_ch_reg    <= in_idx;
            rnd_sum_reg   <= sum_next;
            rnd_slot_reg  <= round_count_reg[in_idx][atmf_pkg::SLOT_W-1:0];
            rnd_final_reg <= (round_count_reg[in_idx] ==
                              atmf_pkg::CNT_W'(atmf_pkg::ROUNDS - 1));
        end
    end

    // round mean: sum / 5 by reciprocal
    logic [atmf_pkg::DIV5_PROD_W-1:0] div5_prod;
    atmf_pkg::value_t                 rnd_avg;

    assign div5_prod = atmf_pkg::DIV5_PROD_W'(rnd_sum_reg)
                     * atmf_pkg::DIV5_PROD_W'(atmf_pkg::DIV5_MUL);
    assign rnd_avg   = div5_prod[atmf_pkg::DIV5_SHIFT +: atmf_pkg::SAMPLE_W];

    always_ff @(posedge clk)
    begin
        if (rnd_valid_reg && !rnd_final_reg)
            avg_mem[rnd_ch_reg][rnd_slot_reg] <= rnd_avg;
    end

    // ---------------- sort stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srt_valid_reg <= 1'b0;
        else if (en_srt)
            srt_valid_reg <= rnd_valid_reg && rnd_final_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_srt)
        begin
            srt_ch_reg <= rnd_ch_reg;
            for (int i = 0; i < atmf_pkg::STORED_ROUNDS; i++)
                srt_vals_reg[i] <= avg_mem[rnd_ch_reg][i];
            srt_vals_reg[atmf_pkg::ROUNDS-1] <= rnd_avg;
        end
    end

    // total minus one minimum and one maximum
    atmf_pkg::value_t               v_min;
    atmf_pkg::value_t               v_max;
    logic [atmf_pkg::TOTAL_W-1:0]   v_total;
    logic [atmf_pkg::TOTAL_W-1:0]   v_mid;

    always_comb
    begin
        v_min   = srt_vals_reg[0];
        v_max   = srt_vals_reg[0];
        v_total = atmf_pkg::TOTAL_W'(srt_vals_reg[0]);
        for (int i = 1; i < atmf_pkg::ROUNDS; i++)
        begin
            v_total = v_total + atmf_pkg::TOTAL_W'(srt_vals_reg[i]);
            if (srt_vals_reg[i] < v_min)
                v_min = srt_vals_reg[i];
            if (srt_vals_reg[i] > v_max)
                v_max = srt_vals_reg[i];
        end
        v_mid = v_total - atmf_pkg::TOTAL_W'(v_min) - atmf_pkg::TOTAL_W'(v_max);
    end

    // ---------------- middle-sum stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (en_mid)
            mid_valid_reg <= srt_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_mid)
        begin
            mid_ch_reg  <= srt_ch_reg;
            mid_sum_reg <= v_mid[atmf_pkg::MID_W-1:0];
        end
    end

    // /3 then /10 truncating equals /30
    logic [atmf_pkg::DIV30_PROD_W-1:0] div30_prod;

    assign div30_prod = atmf_pkg::DIV30_PROD_W'(mid_sum_reg)
                      * atmf_pkg::DIV30_PROD_W'(atmf_pkg::DIV30_MUL);

    // ---------------- quotient stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quo_valid_reg <= 1'b0;
        else if (en_quo)
            quo_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_quo)
        begin
            quo_ch_reg <= mid_ch_reg;
            quo_reg    <= div30_prod[atmf_pkg::DIV30_SHIFT +: atmf_pkg::QUO_W];
        end
    end

    // q * 10 = q*8 + q*2
    atmf_pkg::value_t quo_ext;
    atmf_pkg::value_t scaled;

    assign quo_ext = atmf_pkg::SAMPLE_W'(quo_reg);
    assign scaled  = (quo_ext << 3) + (quo_ext << 1);

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= quo_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_ch_reg    <= quo_ch_reg;
            out_value_reg <= scaled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(out_value_reg);
    assign m_tuser  = 8'(out_ch_reg);

endmodule
